FILE: rtl/pcl_pkg.sv
// Package with shared constants, codes and types of the permutation cycle length core.
package pcl_pkg;

   localparam int ALPHABET_DEF    = 26;
   localparam int TABLE_COUNT_DEF = 3;

   localparam int SEL_W      = 2;
   localparam int ENTRY_W    = 5;
   localparam int OUT_W      = 5;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic REQ_WRITE   = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_WALK,
      ST_HIST_WR,
      ST_FINISH,
      ST_EMIT_RD,
      ST_EMIT_CHK,
      ST_EMIT
   } state_type;

endpackage

FILE: rtl/pcl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/permutation_cycle_lengths_core.sv
// Top level of the permutation cycle length core: table writes, cycle walk and sorted output.
//
//   Channel   Direction  Beat contents
//   req_      in         tuser: req_type; tdata: table_sel, entry_index, entry_value,
//                        entry_defined
//   rsp_      out        tuser: no_cycles; tlast: is_last; tdata: cycle_length, cycle_total
//
// A write beat is taken in the idle state. A compute clears the length histogram, scans
// the start letters, walks each cycle letter by letter and counts each closed cycle in the
// histogram, then scans the length levels from the top (read, check, emit), sends the
// result beats and finishes; the pace is set by the single read port of the table RAM and
// of the histogram RAM.
// Reset clears the defined flags and the control state at once, with no clearing pass.
// A stalled result beat holds the core in its emit state; once the last beat of a compute
// sits in the output register, the next request beat is taken.
module permutation_cycle_lengths_core #(
   parameter int ALPHABET    = pcl_pkg::ALPHABET_DEF,
   parameter int TABLE_COUNT = pcl_pkg::TABLE_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // table_sel[1:0], entry_index[6:2], entry_value[11:7], entry_defined[12], zero fill
   input  logic [pcl_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_type[0]
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cycle_length[4:0], cycle_total[9:5], zero fill
   output logic [pcl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // no_cycles[0]
   output logic [0:0]                      rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int IDX_W   = $clog2(ALPHABET);
   localparam int LEN_W   = $clog2(ALPHABET + 1);
   localparam int ENTRIES = TABLE_COUNT * ALPHABET;
   localparam int TADDR_W = $clog2(ENTRIES);

   logic [pcl_pkg::SEL_W-1:0]   req_sel;
   logic [pcl_pkg::ENTRY_W-1:0] req_index;
   logic [pcl_pkg::ENTRY_W-1:0] req_value;
   logic                        req_def;
   logic                        req_kind;
   logic [TADDR_W-1:0]          wr_entry;

   pcl_pkg::state_type state_ff, state_in;
   logic [TADDR_W-1:0]  base_ff, base_in;
   logic [IDX_W-1:0]    start_ff, start_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    total_ff, total_in;
   logic [LEN_W-1:0]    emit_cnt_ff, emit_cnt_in;
   logic [LEN_W-1:0]    lvl_ff, lvl_in;
   logic [LEN_W-1:0]    rem_ff, rem_in;
   logic [ALPHABET-1:0] visited_ff, visited_in;
   logic [ENTRIES-1:0]  defined_ff, defined_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [pcl_pkg::OUT_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [pcl_pkg::OUT_W-1:0]  rsp_total_ff, rsp_total_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_empty_ff, rsp_empty_in;

   logic                 perm_we;
   logic [TADDR_W-1:0]   perm_waddr;
   logic [IDX_W-1:0]     perm_wdata;
   logic [TADDR_W-1:0]   perm_raddr;
   logic [IDX_W-1:0]     perm_rdata;
   logic                 hist_we;
   logic [IDX_W-1:0]     hist_waddr;
   logic [LEN_W-1:0]     hist_wdata;
   logic [IDX_W-1:0]     hist_raddr;
   logic [LEN_W-1:0]     hist_rdata;

   logic               out_free;
   logic               last_start;
   logic [TADDR_W-1:0] start_entry;
   logic [TADDR_W-1:0] cur_entry;

   assign req_sel   = req_tdata[1:0];
   assign req_index = req_tdata[6:2];
   assign req_value = req_tdata[11:7];
   assign req_def   = req_tdata[12];
   assign req_kind  = req_tuser[0];
   assign wr_entry  = TADDR_W'(32'(req_sel) * ALPHABET + 32'(req_index));

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign last_start  = (start_ff == IDX_W'(ALPHABET - 1));
   assign start_entry = base_ff + TADDR_W'(start_ff);
   assign cur_entry   = base_ff + TADDR_W'(perm_rdata);

   pcl_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_perm_ram (
      .clock   (clock),
      .wr_en   (perm_we),
      .wr_addr (perm_waddr),
      .wr_data (perm_wdata),
      .rd_addr (perm_raddr),
      .rd_data (perm_rdata)
   );

   pcl_ram #(.WIDTH(LEN_W), .DEPTH(ALPHABET)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcl_pkg::ST_IDLE;
         visited_ff   <= '0;
         defined_ff   <= '0;
         total_ff     <= '0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         visited_ff   <= visited_in;
         defined_ff   <= defined_in;
         total_ff     <= total_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff      <= base_in;
      start_ff     <= start_in;
      clr_ff       <= clr_in;
      len_ff       <= len_in;
      lvl_ff       <= lvl_in;
      rem_ff       <= rem_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      start_in     = start_ff;
      clr_in       = clr_ff;
      len_in       = len_ff;
      total_in     = total_ff;
      emit_cnt_in  = emit_cnt_ff;
      lvl_in       = lvl_ff;
      rem_in       = rem_ff;
      visited_in   = visited_ff;
      defined_in   = defined_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_len_in   = rsp_len_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      req_tready   = 1'b0;
      perm_we      = 1'b0;
      perm_waddr   = wr_entry;
      perm_wdata   = IDX_W'(req_value);
      perm_raddr   = start_entry;
      hist_we      = 1'b0;
      hist_waddr   = clr_ff;
      hist_wdata   = '0;
      hist_raddr   = IDX_W'(len_ff - LEN_W'(1));

      unique case (state_ff)
         pcl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_kind == pcl_pkg::REQ_WRITE) begin
                  if (32'(req_sel) < TABLE_COUNT && 32'(req_index) < ALPHABET) begin
                     perm_we              = 1'b1;
                     defined_in[wr_entry] = req_def && (32'(req_value) < ALPHABET);
                  end
               end else begin
                  visited_in  = '0;
                  total_in    = '0;
                  emit_cnt_in = '0;
                  clr_in      = '0;
                  start_in    = '0;
                  base_in     = TADDR_W'(32'(req_sel) * ALPHABET);
                  if (32'(req_sel) < TABLE_COUNT) begin
                     state_in = pcl_pkg::ST_CLEAR;
                  end else begin
                     state_in = pcl_pkg::ST_FINISH;
                  end
               end
            end
         end
         pcl_pkg::ST_CLEAR: begin
            hist_we = 1'b1;
            if (clr_ff == IDX_W'(ALPHABET - 1)) begin
               state_in = pcl_pkg::ST_SCAN;
            end else begin
               clr_in = clr_ff + IDX_W'(1);
            end
         end
         pcl_pkg::ST_SCAN: begin
            visited_in[start_ff] = 1'b1;
            if (!visited_ff[start_ff] && defined_ff[start_entry]) begin
               len_in   = LEN_W'(1);
               state_in = pcl_pkg::ST_WALK;
            end else if (last_start) begin
               state_in = pcl_pkg::ST_FINISH;
            end else begin
               start_in = start_ff + IDX_W'(1);
            end
         end
         pcl_pkg::ST_WALK: begin
            if (perm_rdata == start_ff) begin
               state_in = pcl_pkg::ST_HIST_WR;
            end else begin
               if (len_ff < LEN_W'(ALPHABET)) begin
                  visited_in[perm_rdata] = 1'b1;
               end
               if (len_ff < LEN_W'(ALPHABET) && defined_ff[cur_entry]) begin
                  perm_raddr = cur_entry;
                  len_in     = len_ff + LEN_W'(1);
               end else if (last_start) begin
                  state_in = pcl_pkg::ST_FINISH;
               end else begin
                  start_in = start_ff + IDX_W'(1);
                  state_in = pcl_pkg::ST_SCAN;
               end
            end
         end
         pcl_pkg::ST_HIST_WR: begin
            hist_waddr = IDX_W'(len_ff - LEN_W'(1));
            hist_wdata = hist_rdata + LEN_W'(1);
            if (total_ff < LEN_W'(ALPHABET)) begin
               hist_we  = 1'b1;
               total_in = total_ff + LEN_W'(1);
            end
            if (last_start) begin
               state_in = pcl_pkg::ST_FINISH;
            end else begin
               start_in = start_ff + IDX_W'(1);
               state_in = pcl_pkg::ST_SCAN;
            end
         end
         pcl_pkg::ST_FINISH: begin
            if (total_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_len_in   = '0;
                  rsp_total_in = '0;
                  rsp_last_in  = 1'b1;
                  rsp_empty_in = 1'b1;
                  state_in     = pcl_pkg::ST_IDLE;
               end
            end else begin
               lvl_in   = LEN_W'(ALPHABET);
               state_in = pcl_pkg::ST_EMIT_RD;
            end
         end
         pcl_pkg::ST_EMIT_RD: begin
            hist_raddr = IDX_W'(lvl_ff - LEN_W'(1));
            state_in   = pcl_pkg::ST_EMIT_CHK;
         end
         pcl_pkg::ST_EMIT_CHK: begin
            rem_in   = hist_rdata;
            state_in = pcl_pkg::ST_EMIT;
         end
         pcl_pkg::ST_EMIT: begin
            if (emit_cnt_ff == total_ff) begin
               state_in = pcl_pkg::ST_IDLE;
            end else if (rem_ff == '0) begin
               lvl_in   = lvl_ff - LEN_W'(1);
               state_in = pcl_pkg::ST_EMIT_RD;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = pcl_pkg::OUT_W'(lvl_ff);
               rsp_total_in = pcl_pkg::OUT_W'(total_ff);
               rsp_last_in  = (emit_cnt_ff + LEN_W'(1) == total_ff);
               rsp_empty_in = 1'b0;
               rem_in       = rem_ff - LEN_W'(1);
               emit_cnt_in  = emit_cnt_ff + LEN_W'(1);
            end
         end
         default: begin
            state_in = pcl_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pcl_pkg::RSP_DATA_W - 2 * pcl_pkg::OUT_W){1'b0}},
                        rsp_total_ff, rsp_len_ff};
   assign rsp_tuser  = rsp_empty_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_walk_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == pcl_pkg::ST_WALK |-> (len_ff != '0 && len_ff <= LEN_W'(ALPHABET)))
      else $error("Walk length left its range.");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      emit_cnt_ff <= total_ff)
      else $error("More results emitted than cycles found.");

   a_emit_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcl_pkg::ST_EMIT && emit_cnt_ff != total_ff) |-> lvl_ff != '0)
      else $error("Length scan ran below one with results outstanding.");

   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tlast && rsp_tdata == '0))
      else $error("Empty result beat is not a lone zero beat.");

endmodule

FILE: tb/tb_permutation_cycle_lengths_core.sv
// Self-checking testbench for the permutation cycle length core with a scoreboard class.
`timescale 1ns / 100ps

module tb_permutation_cycle_lengths_core;

   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [pcl_pkg::OUT_W-1:0] length;
      logic [pcl_pkg::OUT_W-1:0] total;
      logic                      last;
      logic                      empty;
   } cycle_beat_type;

   class cycle_scoreboard;
      bit             entry_defined [pcl_pkg::TABLE_COUNT_DEF][pcl_pkg::ALPHABET_DEF];
      int unsigned    entry_letter  [pcl_pkg::TABLE_COUNT_DEF][pcl_pkg::ALPHABET_DEF];
      cycle_beat_type expected_beats [$];
      int unsigned    mismatch_count;
      int unsigned    beats_checked;
      int unsigned    computes_seen;
      int unsigned    writes_seen;

      task report_mismatch(string msg);
         $display("MISMATCH at %0t ns: %s", $time, msg);
         mismatch_count++;
      endtask

      function void predict_cycles(int unsigned sel);
         bit             seen [pcl_pkg::ALPHABET_DEF];
         int unsigned    found [$];
         int unsigned    origin, cur, len, pos, n;
         bit             closed;
         cycle_beat_type beat;
         foreach (seen[i]) seen[i] = 1'b0;
         computes_seen++;
         if (sel < pcl_pkg::TABLE_COUNT_DEF) begin
            for (origin = 0; origin < pcl_pkg::ALPHABET_DEF; origin++) begin
               if (seen[origin]) continue;
               seen[origin] = 1'b1;
               if (!entry_defined[sel][origin]) continue;
               cur = entry_letter[sel][origin];
               len = 1;
               closed = 1'b1;
               while (cur != origin) begin
                  if (len >= pcl_pkg::ALPHABET_DEF) begin
                     closed = 1'b0;
                     break;
                  end
                  seen[cur] = 1'b1;
                  if (!entry_defined[sel][cur]) begin
                     closed = 1'b0;
                     break;
                  end
                  cur = entry_letter[sel][cur];
                  len++;
               end
               if (closed) begin
                  pos = 0;
                  while (pos < found.size() && found[pos] >= len) pos++;
                  found.insert(pos, len);
               end
            end
         end
         n = found.size();
         if (n == 0) begin
            beat.length = '0;
            beat.total  = '0;
            beat.last   = 1'b1;
            beat.empty  = 1'b1;
            expected_beats.push_back(beat);
         end else begin
            for (int unsigned k = 0; k < n; k++) begin
               beat.length = found[k][pcl_pkg::OUT_W-1:0];
               beat.total  = n[pcl_pkg::OUT_W-1:0];
               beat.last   = (k + 1 == n);
               beat.empty  = 1'b0;
               expected_beats.push_back(beat);
            end
         end
      endfunction

      function void note_request(logic kind, int unsigned sel, int unsigned idx,
                                 int unsigned val, int unsigned def);
         if (kind == pcl_pkg::REQ_COMPUTE) begin
            predict_cycles(sel);
         end else begin
            writes_seen++;
            if (sel < pcl_pkg::TABLE_COUNT_DEF && idx < pcl_pkg::ALPHABET_DEF) begin
               entry_defined[sel][idx] = (def != 0) && (val < pcl_pkg::ALPHABET_DEF);
               entry_letter[sel][idx]  = entry_defined[sel][idx] ? val : 0;
            end
         end
      endfunction

      task check_beat(cycle_beat_type got);
         cycle_beat_type want;
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("result beat with no result pending, tdata length %0d",
                                      got.length));
         end else begin
            want = expected_beats.pop_front();
            if (got.length !== want.length)
               report_mismatch($sformatf("beat %0d cycle_length got %0d expected %0d",
                                         beats_checked, got.length, want.length));
            if (got.total !== want.total)
               report_mismatch($sformatf("beat %0d cycle_total got %0d expected %0d",
                                         beats_checked, got.total, want.total));
            if (got.last !== want.last)
               report_mismatch($sformatf("beat %0d tlast got %0b expected %0b",
                                         beats_checked, got.last, want.last));
            if (got.empty !== want.empty)
               report_mismatch($sformatf("beat %0d no_cycles got %0b expected %0b",
                                         beats_checked, got.empty, want.empty));
         end
         beats_checked++;
      endtask
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [pcl_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [0:0]                     req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [pcl_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]                     rsp_tuser;
   logic                           rsp_tlast;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned items_sent;
   int unsigned stall_cycles = 0;

   cycle_scoreboard sb = new();

   permutation_cycle_lengths_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_beat({rsp_tdata[4:0], rsp_tdata[9:5], rsp_tlast, rsp_tuser[0]});
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser[0], 32'(req_tdata[1:0]), 32'(req_tdata[6:2]),
                            32'(req_tdata[11:7]), 32'(req_tdata[12]));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_item(logic kind, int unsigned sel, int unsigned idx,
                            int unsigned val, int unsigned def);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid   = 1'b1;
      req_tuser[0] = kind;
      req_tdata    = {3'b000, def[0], val[4:0], idx[4:0], sel[1:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_tvalid = 1'b0;
      while (sb.expected_beats.size() != 0) @(negedge clock);
   endtask

   task automatic shuffle_letters(ref int unsigned letters[pcl_pkg::ALPHABET_DEF],
                                  input int unsigned count);
      int unsigned j, tmp;
      foreach (letters[i]) letters[i] = i;
      for (int unsigned i = 0; i < count; i++) begin
         j = $urandom_range(pcl_pkg::ALPHABET_DEF - 1, i);
         tmp = letters[i];
         letters[i] = letters[j];
         letters[j] = tmp;
      end
   endtask

   task automatic load_permutation(int unsigned sel, bit single_cycle);
      int unsigned letters[pcl_pkg::ALPHABET_DEF];
      shuffle_letters(letters, pcl_pkg::ALPHABET_DEF);
      for (int unsigned i = 0; i < pcl_pkg::ALPHABET_DEF; i++) begin
         if (single_cycle)
            send_item(pcl_pkg::REQ_WRITE, sel, letters[i],
                      letters[(i + 1) % pcl_pkg::ALPHABET_DEF], 1);
         else
            send_item(pcl_pkg::REQ_WRITE, sel, i, letters[i], 1);
      end
      send_item(pcl_pkg::REQ_COMPUTE, sel, 0, 0, 0);
   endtask

   task automatic write_small_cycle(int unsigned sel);
      int unsigned letters[pcl_pkg::ALPHABET_DEF];
      int unsigned k;
      k = $urandom_range(6, 1);
      shuffle_letters(letters, k);
      for (int unsigned i = 0; i < k; i++)
         send_item(pcl_pkg::REQ_WRITE, sel, letters[i], letters[(i + 1) % k], 1);
   endtask

   task automatic random_round();
      int unsigned pick, sel;
      pick = $urandom_range(99);
      sel  = ($urandom_range(19) == 0) ? 3 : $urandom_range(pcl_pkg::TABLE_COUNT_DEF - 1);
      if (pick < 40)
         send_item(pcl_pkg::REQ_COMPUTE, sel, $urandom_range(31), $urandom_range(31),
                   $urandom_range(1));
      else if (pick < 75)
         write_small_cycle(sel);
      else
         send_item(pcl_pkg::REQ_WRITE, sel, $urandom_range(31), $urandom_range(31),
                   $urandom_range(1));
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      send_idle_pct = 6;
      recv_idle_pct = 70;
      items_sent    = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      send_item(pcl_pkg::REQ_COMPUTE, 0, 0, 0, 0);
      send_item(pcl_pkg::REQ_COMPUTE, 3, 31, 31, 1);
      send_item(pcl_pkg::REQ_WRITE, 0, 0, 0, 1);
      send_item(pcl_pkg::REQ_WRITE, 0, 25, 25, 1);
      send_item(pcl_pkg::REQ_WRITE, 0, 10, 11, 1);
      send_item(pcl_pkg::REQ_WRITE, 0, 11, 10, 1);
      send_item(pcl_pkg::REQ_COMPUTE, 0, 0, 0, 0);
      wait_for_results();
      send_item(pcl_pkg::REQ_WRITE, 1, 1, 2, 1);
      send_item(pcl_pkg::REQ_WRITE, 1, 2, 3, 1);
      send_item(pcl_pkg::REQ_WRITE, 1, 3, 1, 1);
      send_item(pcl_pkg::REQ_WRITE, 1, 4, 2, 1);
      send_item(pcl_pkg::REQ_WRITE, 1, 5, 6, 1);
      send_item(pcl_pkg::REQ_WRITE, 1, 7, 30, 1);
      send_item(pcl_pkg::REQ_WRITE, 1, 31, 0, 1);
      send_item(pcl_pkg::REQ_WRITE, 3, 0, 0, 1);
      send_item(pcl_pkg::REQ_COMPUTE, 1, 0, 0, 0);
      send_item(pcl_pkg::REQ_COMPUTE, 3, 0, 0, 0);
      send_item(pcl_pkg::REQ_WRITE, 0, 25, 25, 0);
      send_item(pcl_pkg::REQ_COMPUTE, 0, 0, 0, 0);
      send_item(pcl_pkg::REQ_WRITE, 1, 3, 0, 0);
      send_item(pcl_pkg::REQ_COMPUTE, 1, 0, 0, 0);

      load_permutation(2, 1'b1);
      while (items_sent < 60) random_round();

      send_idle_pct = 70;
      recv_idle_pct = 6;
      load_permutation($urandom_range(pcl_pkg::TABLE_COUNT_DEF - 1), 1'b0);
      while (items_sent < 95) random_round();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (items_sent < 120) random_round();

      wait_for_results();
      repeat (8 * pcl_pkg::ALPHABET_DEF) @(negedge clock);

      $display("Sent %0d table writes and %0d cycle computes; checked %0d result beats.",
               sb.writes_seen, sb.computes_seen, sb.beats_checked);
      $display("Included empty and out-of-range tables, broken chains, many-to-one maps "
               , "and a full-alphabet cycle.");
      if (sb.mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
